### hdl/comment_skipping_tokenizer_top_defines.svh
// assertion helpers used by the tokenizer output buffer (cst_outbuf)
`ifndef COMMENT_SKIPPING_TOKENIZER_TOP_DEFINES_SVH
`define COMMENT_SKIPPING_TOKENIZER_TOP_DEFINES_SVH

// same-cycle implication
`define CST_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("tokenizer assertion failed");

// next-cycle implication
`define CST_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tokenizer assertion failed");

`endif

### hdl/cst_pkg.sv
package cst_pkg;

    localparam int LINE_BITS = 20;
    localparam int MAX_RES   = 4;
    localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;

    typedef enum logic [2:0] {
        MODE_BETWEEN = 3'd0,
        MODE_TOKEN   = 3'd1,
        MODE_QUOTE   = 3'd2,
        MODE_LINECMT = 3'd3,
        MODE_BLOCK   = 3'd4,
        MODE_BSTAR   = 3'd5
    } t_scan_mode;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_EOT  = 2'd1,
        KIND_SEP  = 2'd2,
        KIND_EOB  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       buffer_first;
        logic       buffer_last;
    } t_in_item;

    typedef struct packed {
        logic [1:0]           result_kind;
        logic [7:0]           token_byte;
        logic [LINE_BITS-1:0] line_number;
        logic                 run_last;
    } t_out_item;

    typedef struct packed {
        logic [1:0]           kind;
        logic [7:0]           tbyte;
        logic [LINE_BITS-1:0] line;
    } t_res_entry;

    // results caused by one text byte
    typedef struct packed {
        logic [2:0]                   cnt;
        t_res_entry [MAX_RES-1:0]     entry;
    } t_res_batch;

endpackage

### hdl/cst_step.sv
module cst_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  cst_pkg::t_in_item  i_item,
    input  logic               i_report,
    output cst_pkg::t_res_batch o_batch
);

    cst_pkg::t_scan_mode               r_mode, n_mode;
    logic                              r_pend, n_pend;
    logic [cst_pkg::LINE_BITS-1:0]     r_line, n_line;

    function automatic cst_pkg::t_res_batch f_emit(
        input cst_pkg::t_res_batch     b,
        input cst_pkg::t_kind          k,
        input logic [7:0]              c,
        input logic [cst_pkg::LINE_BITS-1:0] ln
    );
        cst_pkg::t_res_batch r;
        r = b;
        if (!r.cnt[2]) begin
            r.entry[r.cnt[1:0]].kind  = k;
            r.entry[r.cnt[1:0]].tbyte = (k == cst_pkg::KIND_BYTE) ? c : 8'd0;
            r.entry[r.cnt[1:0]].line  = ln;
            r.cnt = r.cnt + 3'd1;
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= cst_pkg::MODE_BETWEEN;
            r_pend <= 1'b0;
            r_line <= cst_pkg::LINE_BITS'(1);
        end else if (i_go) begin
            r_mode <= n_mode;
            r_pend <= n_pend;
            r_line <= n_line;
        end
    end

    always_comb begin
        logic [7:0]                    c;
        logic                          sep;
        logic                          brace;
        logic                          bumped;
        logic                          run_token;
        logic                          run_between;
        logic [cst_pkg::LINE_BITS-1:0] lc0;
        logic [cst_pkg::LINE_BITS-1:0] lc1;
        logic [cst_pkg::LINE_BITS-1:0] ln;
        cst_pkg::t_res_batch           b;

        c           = i_item.text_byte;
        sep         = (c <= cst_pkg::CH_SPACE) || (c == cst_pkg::CH_SEMI);
        brace       = (c == cst_pkg::CH_LBRACE) || (c == cst_pkg::CH_RBRACE);
        bumped      = 1'b0;
        run_token   = 1'b0;
        run_between = 1'b0;
        b           = '0;

        if (i_item.buffer_first) begin
            n_mode = cst_pkg::MODE_BETWEEN;
            n_pend = 1'b0;
            lc0    = cst_pkg::LINE_BITS'(1);
        end else begin
            n_mode = r_mode;
            n_pend = r_pend;
            lc0    = r_line;
        end
        // saturating line increment
        lc1 = (lc0 == cst_pkg::LINE_MAX) ? lc0 : lc0 + cst_pkg::LINE_BITS'(1);

        if (n_pend) begin
            n_pend = 1'b0;
            if (c == cst_pkg::CH_SLASH) begin
                n_mode = cst_pkg::MODE_LINECMT;
            end else if (c == cst_pkg::CH_STAR) begin
                n_mode = cst_pkg::MODE_BLOCK;
            end else begin
                // lone slash starts a regular token
                b         = f_emit(b, cst_pkg::KIND_BYTE, cst_pkg::CH_SLASH, lc0);
                n_mode    = cst_pkg::MODE_TOKEN;
                run_token = 1'b1;
            end
        end else begin
            unique case (n_mode)
                cst_pkg::MODE_TOKEN: begin
                    run_token = 1'b1;
                end
                cst_pkg::MODE_QUOTE: begin
                    if (c == cst_pkg::CH_QUOTE) begin
                        b      = f_emit(b, cst_pkg::KIND_EOT, 8'd0, lc0);
                        n_mode = cst_pkg::MODE_BETWEEN;
                    end else begin
                        b = f_emit(b, cst_pkg::KIND_BYTE, c, lc0);
                    end
                end
                cst_pkg::MODE_LINECMT: begin
                    if (c == cst_pkg::CH_NL) begin
                        bumped = 1'b1;
                        n_mode = cst_pkg::MODE_BETWEEN;
                        if (i_report) begin
                            b = f_emit(b, cst_pkg::KIND_SEP, 8'd0, lc1);
                        end
                    end
                end
                cst_pkg::MODE_BLOCK: begin
                    if (c == cst_pkg::CH_NL) begin
                        bumped = 1'b1;
                    end
                    if (c == cst_pkg::CH_STAR) begin
                        n_mode = cst_pkg::MODE_BSTAR;
                    end
                end
                cst_pkg::MODE_BSTAR: begin
                    if (c == cst_pkg::CH_SLASH) begin
                        n_mode = cst_pkg::MODE_BETWEEN;
                    end else if (c != cst_pkg::CH_STAR) begin
                        bumped = (c == cst_pkg::CH_NL);
                        n_mode = cst_pkg::MODE_BLOCK;
                    end
                end
                default: begin
                    // between tokens, and any code without meaning
                    n_mode      = cst_pkg::MODE_BETWEEN;
                    run_between = 1'b1;
                end
            endcase
        end

        if (run_token) begin
            if (sep || brace) begin
                b           = f_emit(b, cst_pkg::KIND_EOT, 8'd0, lc0);
                n_mode      = cst_pkg::MODE_BETWEEN;
                run_between = 1'b1;
            end else begin
                b = f_emit(b, cst_pkg::KIND_BYTE, c, lc0);
            end
        end

        if (run_between) begin
            if (sep) begin
                bumped = (c == cst_pkg::CH_NL);
                ln     = bumped ? lc1 : lc0;
                if (i_report && ((c == cst_pkg::CH_NL) || (c == cst_pkg::CH_SEMI))) begin
                    b = f_emit(b, cst_pkg::KIND_SEP, 8'd0, ln);
                end
            end else if (c == cst_pkg::CH_HASH) begin
                n_mode = cst_pkg::MODE_LINECMT;
            end else if (c == cst_pkg::CH_SLASH) begin
                n_pend = 1'b1;
            end else if (c == cst_pkg::CH_QUOTE) begin
                n_mode = cst_pkg::MODE_QUOTE;
            end else if (brace) begin
                b = f_emit(b, cst_pkg::KIND_BYTE, c, lc0);
                b = f_emit(b, cst_pkg::KIND_EOT, 8'd0, lc0);
            end else begin
                b      = f_emit(b, cst_pkg::KIND_BYTE, c, lc0);
                n_mode = cst_pkg::MODE_TOKEN;
            end
        end

        ln = bumped ? lc1 : lc0;

        if (i_item.buffer_last) begin
            if ((n_mode == cst_pkg::MODE_TOKEN) || (n_mode == cst_pkg::MODE_QUOTE)) begin
                b = f_emit(b, cst_pkg::KIND_EOT, 8'd0, ln);
            end else if (n_pend) begin
                b = f_emit(b, cst_pkg::KIND_BYTE, cst_pkg::CH_SLASH, ln);
                b = f_emit(b, cst_pkg::KIND_EOT, 8'd0, ln);
            end
            if (b.cnt[2]) begin
                // full batch: end of buffer takes the last slot
                b.entry[cst_pkg::MAX_RES-1].kind  = cst_pkg::KIND_EOB;
                b.entry[cst_pkg::MAX_RES-1].tbyte = 8'd0;
                b.entry[cst_pkg::MAX_RES-1].line  = ln;
            end else begin
                b = f_emit(b, cst_pkg::KIND_EOB, 8'd0, ln);
            end
            n_mode = cst_pkg::MODE_BETWEEN;
            n_pend = 1'b0;
        end

        n_line  = ln;
        o_batch = b;
    end

endmodule

### hdl/cst_outbuf.sv
`include "comment_skipping_tokenizer_top_defines.svh"

module cst_outbuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  cst_pkg::t_res_batch i_batch,
    input  logic                i_stall,
    output logic                o_valid,
    output cst_pkg::t_out_item  o_item,
    output logic                o_free
);

    logic [2:0]                             r_left;
    logic [1:0]                             r_idx;
    cst_pkg::t_res_entry [cst_pkg::MAX_RES-1:0] r_entry;

    assign o_valid = (r_left != 3'd0);
    // empty, or the last entry leaves this cycle
    assign o_free  = (r_left == 3'd0) || ((r_left == 3'd1) && !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
            r_idx  <= 2'd0;
        end else if (i_load) begin
            r_left <= i_batch.cnt;
            r_idx  <= 2'd0;
        end else if (o_valid && !i_stall) begin
            r_left <= r_left - 3'd1;
            r_idx  <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= i_batch.entry;
        end
    end

    always_comb begin
        o_item.result_kind = r_entry[r_idx].kind;
        o_item.token_byte  = r_entry[r_idx].tbyte;
        o_item.line_number = r_entry[r_idx].line;
        o_item.run_last    = (r_left == 3'd1);
    end

    `CST_ASSERT_NOW(a_load_when_free, i_clk, i_rst_n, i_load, o_free)
    `CST_ASSERT_NOW(a_batch_bound, i_clk, i_rst_n, i_load, i_batch.cnt <= 3'd4)
    `CST_ASSERT_NEXT(a_drain_step, i_clk, i_rst_n, (r_left > 3'd1) && !i_stall, (r_left == $past(r_left) - 3'd1) && (r_idx == $past(r_idx) + 2'd1))

endmodule

### hdl/comment_skipping_tokenizer_top.sv
// Streaming tokenizer: one text byte per input transfer, results (token bytes, end of
// token, line separators, end of buffer) one per output transfer. Line comments ('#',
// '//') and block comments are skipped at token starts. report_line_breaks is written through
// i_cfg_we / i_cfg_data; the user must write it only while no byte is in flight, as the block
// does not enforce this. A byte is taken every cycle as long as the output is not stalled and
// each byte yields at most one result; a byte with more results (up to four) holds the input
// while the result buffer hands them out, one entry per unstalled cycle.
module comment_skipping_tokenizer_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cst_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cst_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_data
);

    logic                r_in_vld;
    cst_pkg::t_in_item   r_in;
    logic                r_report;
    logic                free;
    logic                go;
    cst_pkg::t_res_batch batch;

    assign go         = r_in_vld && free;
    assign o_in_stall = r_in_vld && !free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_report <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_vld <= 1'b1;
            end else if (go) begin
                r_in_vld <= 1'b0;
            end
            if (i_cfg_we) begin
                r_report <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
    end

    cst_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_item   (r_in),
        .i_report (r_report),
        .o_batch  (batch)
    );

    cst_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (go),
        .i_batch (batch),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .o_free  (free)
    );

endmodule
